@@ hdl/lfps_pkg.sv @@
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared constants, types and the duty lookup table of the line-follow PI
// steering block.
// ----------------------------------------------------------------------------
package lfps_pkg;

    // Geometry of the sensor bar and of the error smoothing filter.
    localparam int SENSOR_COUNT = 7;
    localparam int AVERAGE_TAPS = 5;

    localparam int SENS_IDX_W = $clog2(SENSOR_COUNT);
    localparam int HIST_IDX_W = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
    localparam int LOOP_MAX   = (SENSOR_COUNT > AVERAGE_TAPS) ? SENSOR_COUNT : AVERAGE_TAPS;
    localparam int LOOP_W     = $clog2(LOOP_MAX + 1);

    // Datapath widths.
    localparam int AVG_W   = 24;   // Q16.8 channel average
    localparam int ERR_W   = 13;   // Q5.8 line error
    localparam int HSUM_W  = 18;   // sum of the error history
    localparam int INT_W   = 20;   // Q8.12 integral
    localparam int MAC_A_W = 22;
    localparam int MAC_B_W = 27;
    localparam int MAC_P_W = 49;

    // Division by the tap count: rounded-up reciprocal, exact for |sum| < 2^17.
    localparam int DIV_SHIFT = 24;
    localparam int DIV_RECIP = ((1 << DIV_SHIFT) + AVERAGE_TAPS - 1) / AVERAGE_TAPS;

    // Line error constants, Q5.8.
    localparam int WEIGHT_HALF_SPAN = (SENSOR_COUNT - 1) * 128;
    localparam int LOST_LIMIT       = (SENSOR_COUNT - 1) * 256;
    localparam int ERR_MIN          = -4096;
    localparam int ERR_MAX          = 4095;

    // Controller output and servo constants.
    localparam int CTRL_MAX        = 100;
    localparam int CTRL_LIMIT_Q12  = CTRL_MAX * 4096;
    localparam int PULSE_CENTER_US = 1500;
    localparam int SERVO_FRAME_US  = 20000;
    localparam int DUTY_FULL       = 65535;

    // Configuration register reset values.
    localparam logic [15:0] EMA_ALPHA_RST      = 16'd19661;
    localparam logic [15:0] CLEAR_THR_RST      = 16'd6000;
    localparam logic [15:0] BLUE_THR_RST       = 16'd1600;
    localparam logic [14:0] PROP_GAIN_RST      = 15'd2048;
    localparam logic [14:0] INTEGRAL_GAIN_RST  = 15'd82;
    localparam logic [6:0]  INTEGRAL_LIMIT_RST = 7'd50;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_EMA_ALPHA      = 3'd0,
        CFG_CLEAR_THR      = 3'd1,
        CFG_BLUE_THR       = 3'd2,
        CFG_PROP_GAIN      = 3'd3,
        CFG_INTEGRAL_GAIN  = 3'd4,
        CFG_INTEGRAL_LIMIT = 3'd5
    } cfg_index_t;

    // One request to the shared multiply-accumulate unit: en loads a * b + c.
    typedef struct packed {
        logic                       en;
        logic signed [MAC_A_W-1:0]  a;
        logic signed [MAC_B_W-1:0]  b;
        logic signed [MAC_P_W-1:0]  c;
    } mac_req_t;

    // Duty value for each control value, indexed by control + CTRL_MAX.
    typedef logic [12:0] duty_table_t [0:2*CTRL_MAX];

    function automatic duty_table_t build_duty_table();
        duty_table_t tbl;
        for (int k = 0; k <= 2 * CTRL_MAX; k++) begin
            tbl[k] = 13'(((PULSE_CENTER_US + 4 * (k - CTRL_MAX)) * DUTY_FULL) / SERVO_FRAME_US);
        end
        return tbl;
    endfunction

    localparam duty_table_t DUTY_TABLE = build_duty_table();

endpackage

@@ hdl/lfps_mac.sv @@
// ----------------------------------------------------------------------------
// lfps_mac
// Shared signed multiply-accumulate unit with a registered result.
// ----------------------------------------------------------------------------
module lfps_mac
    import lfps_pkg::*;
(
    input  logic                       aclk,
    input  mac_req_t                   req,
    output logic signed [MAC_P_W-1:0]  result
);

    logic signed [MAC_P_W-1:0] result_reg;
    logic signed [MAC_P_W-1:0] result_next;

    // All operands are sign-extended to the result width before the product.
    assign result_next = req.a * req.b + req.c;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

@@ hdl/line_follow_pi_steering.sv @@
// ----------------------------------------------------------------------------
// line_follow_pi_steering
// Color-sensor line follower: per-sensor averaging, line error, smoothing,
// PI control and servo pulse generation.
// ----------------------------------------------------------------------------
// Readings enter one beat at a time; the source must send them in
// ascending sensor order, which the block itself does not enforce. The
// block drops s_tready while it works on one. All multiplications and the
// weight and history sums run through a single multiply-accumulate unit,
// one step after another: a reading updates its sensor's clear and blue
// averages (a first reading only seeds them) and white bit, a reading with
// an index at or above SENSOR_COUNT is dropped without work, and the last
// sensor's reading then also walks the weight sum over the sensors and the
// smoothing filter over its taps, one per cycle, before the division and
// the PI steps. The result beat sits in an output register; a frame that
// ends while the previous result still waits holds until it is taken.
// Configuration writes are registered and accepted in any state.
// ----------------------------------------------------------------------------
module line_follow_pi_steering
    import lfps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input readings.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // clear_count[15:0], blue_count[31:16]
    input  logic [2:0]  s_tuser,   // sensor_index[2:0]
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // duty_value[12:0], pulse_width[23:13],
                                   // control_value[31:24], smoothed_error[43:32],
                                   // white_mask[50:44], zero[55:51]
    output logic [0:0]  m_tuser,   // line_lost[0]
    // Configuration writes.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_BLUE,
        ST_BLUE_WR,
        ST_WHITE,
        ST_WSUM,
        ST_RAW,
        ST_HSUM,
        ST_DIV,
        ST_DIVQ,
        ST_PMUL,
        ST_IMUL,
        ST_ISUM,
        ST_OSUM,
        ST_CTRL,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [15:0] ema_alpha_reg;
    logic [15:0] clear_thr_reg;
    logic [15:0] blue_thr_reg;
    logic [14:0] prop_gain_reg;
    logic [14:0] integral_gain_reg;
    logic [6:0]  integral_limit_reg;

    // Current reading.
    logic [SENS_IDX_W-1:0] sensor_reg;
    logic [15:0]           clear_in_reg;
    logic [15:0]           blue_in_reg;
    logic [LOOP_W-1:0]     cnt_reg;

    // Per-sensor state.
    logic [AVG_W-1:0]        clear_avg_mem [SENSOR_COUNT];
    logic [AVG_W-1:0]        blue_avg_mem  [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] seeded_reg;
    logic [SENSOR_COUNT-1:0] white_reg;

    // Error filter and controller state.
    logic signed [ERR_W-1:0] hist_reg [AVERAGE_TAPS];
    logic [HIST_IDX_W-1:0]   slot_reg;
    logic signed [ERR_W-1:0] last_sm_reg;
    logic signed [ERR_W-1:0] sm_reg;
    logic                    hneg_reg;
    logic                    lost_reg;
    logic signed [20:0]      p_reg;
    logic signed [INT_W-1:0] integral_reg;
    logic signed [21:0]      o_reg;
    logic signed [7:0]       ctrl_reg;

    // Output registers.
    logic        m_valid_reg;
    logic [12:0] duty_out_reg;
    logic [10:0] pulse_out_reg;
    logic [7:0]  ctrl_out_reg;
    logic [11:0] sm_out_reg;
    logic [6:0]  white_out_reg;
    logic        lost_out_reg;

    // Shared unit.
    mac_req_t                  mac_req;
    logic signed [MAC_P_W-1:0] mac_res;

    lfps_mac u_mac (
        .aclk   (aclk),
        .req    (mac_req),
        .result (mac_res)
    );

    // Datapath signals.
    logic [AVG_W-1:0]          clear_cur;
    logic [AVG_W-1:0]          blue_cur;
    logic [AVG_W-1:0]          clear_seed;
    logic [AVG_W-1:0]          blue_seed;
    logic signed [24:0]        d_clear;
    logic signed [24:0]        d_blue;
    logic                      is_seeded;
    logic                      is_white;
    logic                      in_range;
    logic signed [15:0]        weight;
    logic signed [15:0]        wsum;
    logic signed [ERR_W-1:0]   raw_found;
    logic signed [14:0]        three_last;
    logic signed [14:0]        half_last;
    logic signed [ERR_W-1:0]   raw_lost;
    logic signed [ERR_W-1:0]   raw_err;
    logic                      frame_lost;
    logic signed [HSUM_W-1:0]  hsum;
    logic signed [HSUM_W-1:0]  hsum_abs;
    logic [13:0]               quot;
    logic signed [13:0]        quot_signed;
    logic signed [28:0]        gain_prod;
    logic signed [28:0]        gain_adj;
    logic signed [20:0]        gain_q12;
    logic signed [21:0]        isum;
    logic signed [21:0]        ilim;
    logic signed [21:0]        isum_clamped;
    logic signed [21:0]        osum;
    logic signed [21:0]        osum_clamped;
    logic signed [21:0]        o_adj;
    logic [8:0]                duty_idx;
    logic [11:0]               pulse_wide;
    logic [6:0]                white_low;
    logic                      out_free;

    // Averages and per-reading quantities.
    always_comb begin
        clear_cur  = clear_avg_mem[sensor_reg];
        blue_cur   = blue_avg_mem[sensor_reg];
        clear_seed = {clear_in_reg, 8'h00};
        blue_seed  = {blue_in_reg, 8'h00};
        d_clear    = $signed({1'b0, clear_seed}) - $signed({1'b0, clear_cur});
        d_blue     = $signed({1'b0, blue_seed}) - $signed({1'b0, blue_cur});
        is_seeded  = seeded_reg[sensor_reg];
        is_white   = (clear_cur > {clear_thr_reg, 8'h00}) && (blue_cur > {blue_thr_reg, 8'h00});
        in_range   = 5'(s_tuser) < 5'(SENSOR_COUNT);
    end

    // Line error, with the recovery rule when no sensor sees white.
    always_comb begin
        weight = $signed({{(8 - LOOP_W){1'b0}}, cnt_reg, 8'h00})
                 - $signed(16'(WEIGHT_HALF_SPAN));
        wsum   = $signed(mac_res[15:0]);
        if (wsum > $signed(16'(ERR_MAX))) begin
            raw_found = ERR_W'(ERR_MAX);
        end else if (wsum < $signed(16'(ERR_MIN))) begin
            raw_found = ERR_W'(ERR_MIN);
        end else begin
            raw_found = wsum[ERR_W-1:0];
        end

        // Three halves of the last error, rounded toward zero.
        three_last = {{2{last_sm_reg[ERR_W-1]}}, last_sm_reg}
                   + {last_sm_reg[ERR_W-1], last_sm_reg, 1'b0};
        half_last  = (three_last + $signed({14'd0, three_last[14]})) >>> 1;
        if (last_sm_reg == '0) begin
            raw_lost = ERR_W'(LOST_LIMIT);
        end else if (half_last > $signed(15'(LOST_LIMIT))) begin
            raw_lost = ERR_W'(LOST_LIMIT);
        end else if (half_last < -$signed(15'(LOST_LIMIT))) begin
            raw_lost = ERR_W'(-LOST_LIMIT);
        end else begin
            raw_lost = half_last[ERR_W-1:0];
        end

        frame_lost = (white_reg == '0);
        raw_err    = frame_lost ? raw_lost : raw_found;
    end

    // Smoothing division and PI arithmetic.
    always_comb begin
        hsum        = $signed(mac_res[HSUM_W-1:0]);
        hsum_abs    = hsum[HSUM_W-1] ? -hsum : hsum;
        quot        = mac_res[DIV_SHIFT+13:DIV_SHIFT];
        quot_signed = hneg_reg ? -$signed(quot) : $signed(quot);

        // Gain product scaled by 1/256, rounded toward zero.
        gain_prod = $signed(mac_res[28:0]);
        gain_adj  = gain_prod + (gain_prod[28] ? 29'sd255 : 29'sd0);
        gain_q12  = gain_adj[28:8];

        isum = {{2{integral_reg[INT_W-1]}}, integral_reg} + {gain_q12[20], gain_q12};
        ilim = $signed({3'b000, integral_limit_reg, 12'h000});
        if (isum > ilim) begin
            isum_clamped = ilim;
        end else if (isum < -ilim) begin
            isum_clamped = -ilim;
        end else begin
            isum_clamped = isum;
        end

        osum = {p_reg[20], p_reg} + {{2{integral_reg[INT_W-1]}}, integral_reg};
        if (osum > $signed(22'(CTRL_LIMIT_Q12))) begin
            osum_clamped = 22'(CTRL_LIMIT_Q12);
        end else if (osum < -$signed(22'(CTRL_LIMIT_Q12))) begin
            osum_clamped = -$signed(22'(CTRL_LIMIT_Q12));
        end else begin
            osum_clamped = osum;
        end
        o_adj = o_reg + (o_reg[21] ? 22'sd4095 : 22'sd0);

        duty_idx   = {ctrl_reg[7], ctrl_reg} + 9'(CTRL_MAX);
        pulse_wide = 12'(PULSE_CENTER_US) + {{2{ctrl_reg[7]}}, ctrl_reg, 2'b00};
        out_free   = !m_valid_reg || m_tready;
    end

    // White mask as seen on the output, low bits only.
    always_comb begin
        white_low = '0;
        for (int i = 0; i < SENSOR_COUNT && i < 7; i++) begin
            white_low[i] = white_reg[i];
        end
    end

    // Requests to the shared unit for each step.
    always_comb begin
        mac_req = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                mac_req.en = 1'b1;
                mac_req.a  = $signed({6'd0, ema_alpha_reg});
                mac_req.b  = {{2{d_clear[24]}}, d_clear};
                mac_req.c  = $signed({9'd0, clear_cur, 16'h8000});
            end
            ST_BLUE: begin
                mac_req.en = 1'b1;
                mac_req.a  = $signed({6'd0, ema_alpha_reg});
                mac_req.b  = {{2{d_blue[24]}}, d_blue};
                mac_req.c  = $signed({9'd0, blue_cur, 16'h8000});
            end
            ST_WSUM: begin
                mac_req.en = 1'b1;
                mac_req.a  = white_reg[cnt_reg[SENS_IDX_W-1:0]] ? {{6{weight[15]}}, weight} : '0;
                mac_req.b  = 27'sd1;
                mac_req.c  = (cnt_reg == '0) ? '0 : mac_res;
            end
            ST_HSUM: begin
                mac_req.en = 1'b1;
                mac_req.a  = {{(MAC_A_W - ERR_W){hist_reg[cnt_reg[HIST_IDX_W-1:0]][ERR_W-1]}},
                              hist_reg[cnt_reg[HIST_IDX_W-1:0]]};
                mac_req.b  = 27'sd1;
                mac_req.c  = (cnt_reg == '0) ? '0 : mac_res;
            end
            ST_DIV: begin
                mac_req.en = 1'b1;
                mac_req.a  = {{(MAC_A_W - HSUM_W){1'b0}}, hsum_abs};
                mac_req.b  = MAC_B_W'(DIV_RECIP);
            end
            ST_PMUL: begin
                mac_req.en = 1'b1;
                mac_req.a  = $signed({7'd0, prop_gain_reg});
                mac_req.b  = {{(MAC_B_W - ERR_W){sm_reg[ERR_W-1]}}, sm_reg};
            end
            ST_IMUL: begin
                mac_req.en = 1'b1;
                mac_req.a  = $signed({7'd0, integral_gain_reg});
                mac_req.b  = {{(MAC_B_W - ERR_W){sm_reg[ERR_W-1]}}, sm_reg};
            end
            default: begin
                mac_req = '0;
            end
        endcase
    end

    // Channel averages: seeded by the first reading, then updated by the EMA.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR && !is_seeded) begin
            clear_avg_mem[sensor_reg] <= clear_seed;
            blue_avg_mem[sensor_reg]  <= blue_seed;
        end
        if (state_reg == ST_BLUE) begin
            clear_avg_mem[sensor_reg] <= mac_res[39:16];
        end
        if (state_reg == ST_BLUE_WR) begin
            blue_avg_mem[sensor_reg] <= mac_res[39:16];
        end
    end

    // Sequencer, configuration and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            cnt_reg            <= '0;
            seeded_reg         <= '0;
            white_reg          <= '0;
            for (int i = 0; i < AVERAGE_TAPS; i++) begin
                hist_reg[i] <= '0;
            end
            slot_reg           <= '0;
            last_sm_reg        <= '0;
            integral_reg       <= '0;
            m_valid_reg        <= 1'b0;
            ema_alpha_reg      <= EMA_ALPHA_RST;
            clear_thr_reg      <= CLEAR_THR_RST;
            blue_thr_reg       <= BLUE_THR_RST;
            prop_gain_reg      <= PROP_GAIN_RST;
            integral_gain_reg  <= INTEGRAL_GAIN_RST;
            integral_limit_reg <= INTEGRAL_LIMIT_RST;
        end else begin
            // Configuration writes, masked to each register's width.
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_EMA_ALPHA:      ema_alpha_reg      <= cfg_wdata;
                    CFG_CLEAR_THR:      clear_thr_reg      <= cfg_wdata;
                    CFG_BLUE_THR:       blue_thr_reg       <= cfg_wdata;
                    CFG_PROP_GAIN:      prop_gain_reg      <= cfg_wdata[14:0];
                    CFG_INTEGRAL_GAIN:  integral_gain_reg  <= cfg_wdata[14:0];
                    CFG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_wdata[6:0];
                    default: ;
                endcase
            end

            // A taken beat empties the output register unless a new one loads.
            if (m_valid_reg && m_tready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && in_range) begin
                        sensor_reg   <= SENS_IDX_W'(s_tuser);
                        clear_in_reg <= s_tdata[15:0];
                        blue_in_reg  <= s_tdata[31:16];
                        state_reg    <= ST_CLEAR;
                    end
                end
                ST_CLEAR: begin
                    if (!is_seeded) begin
                        seeded_reg[sensor_reg] <= 1'b1;
                        state_reg              <= ST_WHITE;
                    end else begin
                        state_reg <= ST_BLUE;
                    end
                end
                ST_BLUE: begin
                    state_reg <= ST_BLUE_WR;
                end
                ST_BLUE_WR: begin
                    state_reg <= ST_WHITE;
                end
                ST_WHITE: begin
                    white_reg[sensor_reg] <= is_white;
                    cnt_reg               <= '0;
                    if (sensor_reg == SENS_IDX_W'(SENSOR_COUNT - 1)) begin
                        state_reg <= ST_WSUM;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                // Walk the sensors, adding the weight of each white one.
                ST_WSUM: begin
                    if (cnt_reg == LOOP_W'(SENSOR_COUNT - 1)) begin
                        state_reg <= ST_RAW;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_RAW: begin
                    hist_reg[slot_reg] <= raw_err;
                    lost_reg           <= frame_lost;
                    if (slot_reg == HIST_IDX_W'(AVERAGE_TAPS - 1)) begin
                        slot_reg <= '0;
                    end else begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                    cnt_reg   <= '0;
                    state_reg <= ST_HSUM;
                end
                // Walk the error history taps.
                ST_HSUM: begin
                    if (cnt_reg == LOOP_W'(AVERAGE_TAPS - 1)) begin
                        state_reg <= ST_DIV;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DIV: begin
                    hneg_reg  <= hsum[HSUM_W-1];
                    state_reg <= ST_DIVQ;
                end
                ST_DIVQ: begin
                    sm_reg      <= quot_signed[ERR_W-1:0];
                    last_sm_reg <= quot_signed[ERR_W-1:0];
                    state_reg   <= ST_PMUL;
                end
                ST_PMUL: begin
                    state_reg <= ST_IMUL;
                end
                ST_IMUL: begin
                    p_reg     <= gain_q12;
                    state_reg <= ST_ISUM;
                end
                ST_ISUM: begin
                    integral_reg <= isum_clamped[INT_W-1:0];
                    state_reg    <= ST_OSUM;
                end
                ST_OSUM: begin
                    o_reg     <= osum_clamped;
                    state_reg <= ST_CTRL;
                end
                ST_CTRL: begin
                    ctrl_reg  <= o_adj[19:12];
                    state_reg <= ST_EMIT;
                end
                // Hand the result to the output register once it is free.
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        duty_out_reg  <= DUTY_TABLE[duty_idx[7:0]];
                        pulse_out_reg <= pulse_wide[10:0];
                        ctrl_out_reg  <= ctrl_reg;
                        sm_out_reg    <= sm_reg[11:0];
                        white_out_reg <= white_low;
                        lost_out_reg  <= lost_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {5'd0, white_out_reg, sm_out_reg, ctrl_out_reg,
                         pulse_out_reg, duty_out_reg};
    assign m_tuser[0] = lost_out_reg;

endmodule

@@ hdl/lfps_checker.sv @@
// ----------------------------------------------------------------------------
// lfps_checker
// Port-level checks of the line-follow PI steering block, bound to the top.
// ----------------------------------------------------------------------------
module lfps_checker
    import lfps_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [0:0]  m_tuser
);

    logic signed [7:0]  ctrl_val;
    logic [11:0]        pulse_expect;
    logic               idx_valid;

    assign ctrl_val     = $signed(m_tdata[31:24]);
    assign pulse_expect = 12'd1500 + {{2{ctrl_val[7]}}, ctrl_val, 2'b00};
    assign idx_valid    = {1'b0, s_tuser} < 4'(SENSOR_COUNT);

    // A held result beat keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // The block works on one reading at a time; a dropped index needs no work.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && s_tvalid && s_tready && idx_valid |=> !s_tready)
        else $error("ready stayed high after an accepted reading");

    // Pulse width follows the control value, which stays within its clamp.
    a_pulse_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:13] == pulse_expect[10:0])
                     && (ctrl_val <= 8'sd100) && (ctrl_val >= -8'sd100))
        else $error("pulse width does not match control value");

    // A lost line means no sensor in the mask is white.
    a_lost_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[50:44] == 7'd0))
        else $error("line lost reported with white sensors set");

endmodule

bind line_follow_pi_steering lfps_checker u_lfps_checker (.*);

@@ tb/sv/tb_line_follow_pi_steering.sv @@
// ----------------------------------------------------------------------------
// tb_line_follow_pi_steering
// Self-checking testbench of the line-follow PI steering block.
// ----------------------------------------------------------------------------
// Sensor readings are sent beat by beat on the input stream. A predictor
// built into this testbench tracks the per-sensor averages, the white
// classification, the error smoothing filter and the PI controller. It
// queues one expected steering result for every frame that a reading of
// the last sensor closes. Every result beat is checked field by field
// against the oldest queued result.
//
// The run has these parts:
// - a short directed part with saturated and zero counts, skipped sensors,
//   an out-of-range index and both recovery rules for a lost line;
// - extreme register settings;
// - random traffic in four phases of back-pressure and source gaps.
// Registers are only rewritten once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb_line_follow_pi_steering;
    timeunit 1ns;
    timeprecision 1ps;

    import lfps_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_READS   = 375;

    // One expected steering result.
    typedef struct {
        logic [12:0] duty;
        logic [10:0] pulse;
        logic [7:0]  control;
        logic [11:0] smoothed;
        logic [6:0]  mask;
        logic        lost;
    } steer_result_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // clear_count[15:0], blue_count[31:16]
    logic [2:0]  s_tuser   = '0;   // sensor_index[2:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;          // duty_value[12:0], pulse_width[23:13],
                                   // control_value[31:24], smoothed_error[43:32],
                                   // white_mask[50:44], zero[55:51]
    logic [0:0]  m_tuser;          // line_lost[0]
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    // Predictor copy of the registers.
    logic [15:0] alpha_cfg;
    logic [15:0] clear_thr_cfg;
    logic [15:0] blue_thr_cfg;
    logic [14:0] kp_cfg;
    logic [14:0] ki_cfg;
    logic [6:0]  ilimit_cfg;

    // Predictor copy of the block state.
    logic [23:0]             clear_avg [SENSOR_COUNT];
    logic [23:0]             blue_avg  [SENSOR_COUNT];
    bit                      seeded    [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] white_bits;
    int                      err_hist  [AVERAGE_TAPS];
    int                      hist_slot;
    int                      last_smoothed;
    int                      integral_acc;

    steer_result_t expected_steering [$];

    int failures       = 0;
    int readings_sent  = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    line_follow_pi_steering dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock with a 10 ns period.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Run-time guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiver stalls at random, as the current phase asks.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Exponential average step in Q16.8 with rounding.
    function automatic logic [23:0] ema_next(logic [23:0] avg, logic [15:0] count);
        longint unsigned a;
        longint unsigned c;
        longint unsigned acc;
        a   = alpha_cfg;
        c   = count;
        acc = a * (c << 8) + (65536 - a) * avg + 32768;
        return acc[39:16];
    endfunction

    // Advance the predictor by one reading and queue the steering result
    // when the reading closes a frame.
    function automatic void predict_steering(logic [2:0] idx, logic [15:0] clear,
                                             logic [15:0] blue);
        int            raw;
        int            hsum;
        int            sm;
        int            ctrl;
        int            pulse;
        longint        p;
        longint        inc;
        longint        ilim;
        longint        isum;
        longint        o;
        steer_result_t r;

        // Readings from a sensor that does not exist are dropped.
        if (idx >= SENSOR_COUNT) return;

        if (!seeded[idx]) begin
            clear_avg[idx] = {clear, 8'd0};
            blue_avg[idx]  = {blue, 8'd0};
            seeded[idx]    = 1'b1;
        end else begin
            clear_avg[idx] = ema_next(clear_avg[idx], clear);
            blue_avg[idx]  = ema_next(blue_avg[idx], blue);
        end
        white_bits[idx] = (clear_avg[idx] > {clear_thr_cfg, 8'd0}) &&
                          (blue_avg[idx] > {blue_thr_cfg, 8'd0});
        if (idx != SENSOR_COUNT - 1) return;

        // Line error from the white sensors, or the recovery rule.
        if (white_bits != '0) begin
            raw = 0;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                if (white_bits[i]) raw += i * 256 - (SENSOR_COUNT - 1) * 128;
            end
            raw = int'(clip(raw, -4096, 4095));
        end else begin
            raw = (last_smoothed == 0) ? (SENSOR_COUNT - 1) * 256 : (3 * last_smoothed) / 2;
            raw = int'(clip(raw, -(SENSOR_COUNT - 1) * 256, (SENSOR_COUNT - 1) * 256));
        end

        // Moving average over the error history.
        err_hist[hist_slot] = raw;
        hist_slot = (hist_slot + 1) % AVERAGE_TAPS;
        hsum = 0;
        for (int i = 0; i < AVERAGE_TAPS; i++) hsum += err_hist[i];
        sm = hsum / AVERAGE_TAPS;
        last_smoothed = sm;

        // PI controller in Q.12, every division truncating toward zero.
        p    = (longint'(kp_cfg) * sm) / 256;
        inc  = (longint'(ki_cfg) * sm) / 256;
        ilim = longint'(ilimit_cfg) << 12;
        isum = clip(integral_acc + inc, -ilim, ilim);
        integral_acc = int'(isum);
        o     = clip(p + isum, -(100 * 4096), 100 * 4096);
        ctrl  = int'(o / 4096);
        pulse = 1500 + 4 * ctrl;

        r.duty     = 13'((pulse * 65535) / 20000);
        r.pulse    = 11'(pulse);
        r.control  = 8'(ctrl);
        r.smoothed = 12'(sm);
        r.mask     = white_bits[6:0];
        r.lost     = (white_bits == '0);
        expected_steering.push_back(r);
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // Check each result beat against the oldest expected result.
    always @(posedge aclk) begin
        steer_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_steering.size() == 0) begin
                $error("result beat arrived with no expected result");
                failures++;
            end else begin
                want = expected_steering.pop_front();
                check_field("duty_value", want.duty, m_tdata[12:0]);
                check_field("pulse_width", want.pulse, m_tdata[23:13]);
                check_field("control_value", $signed(want.control), $signed(m_tdata[31:24]));
                check_field("smoothed_error", $signed(want.smoothed),
                            $signed(m_tdata[43:32]));
                check_field("white_mask", want.mask, m_tdata[50:44]);
                check_field("line_lost", want.lost, m_tuser[0]);
            end
        end
    end

    // Send one reading beat and feed it to the predictor once accepted.
    task automatic send_reading(logic [2:0] idx, logic [15:0] clear, logic [15:0] blue);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = idx;
        s_tdata  = {blue, clear};
        do @(posedge aclk); while (!s_tready);
        predict_steering(idx, clear, blue);
        if (idx < SENSOR_COUNT) readings_sent++;
    endtask

    // Stop sending, let every expected result drain, then let the block
    // finish any reading that causes no result.
    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_steering.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            CFG_EMA_ALPHA:      alpha_cfg     = value;
            CFG_CLEAR_THR:      clear_thr_cfg = value;
            CFG_BLUE_THR:       blue_thr_cfg  = value;
            CFG_PROP_GAIN:      kp_cfg        = value[14:0];
            CFG_INTEGRAL_GAIN:  ki_cfg        = value[14:0];
            CFG_INTEGRAL_LIMIT: ilimit_cfg    = value[6:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [15:0] alpha, logic [15:0] clear_thr,
                                  logic [15:0] blue_thr, logic [14:0] kp,
                                  logic [14:0] ki, logic [6:0] ilimit);
        wait_quiet();
        write_reg(CFG_EMA_ALPHA, alpha);
        write_reg(CFG_CLEAR_THR, clear_thr);
        write_reg(CFG_BLUE_THR, blue_thr);
        write_reg(CFG_PROP_GAIN, {1'b0, kp});
        write_reg(CFG_INTEGRAL_GAIN, {1'b0, ki});
        write_reg(CFG_INTEGRAL_LIMIT, {9'd0, ilimit});
    endtask

    // A count that lands above or below a threshold, with some fully random.
    function automatic logic [15:0] pick_count(bit bright, logic [15:0] thr);
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        if (bright) return (thr == 16'hFFFF) ? thr : 16'($urandom_range(int'(thr) + 1, 65535));
        return 16'($urandom_range(0, int'(thr)));
    endfunction

    // Which sensors should see white: a narrow line, a random mask, no
    // line at all, or a fully white bar.
    function automatic logic [SENSOR_COUNT-1:0] choose_pattern();
        int kind;
        int width;
        int pos;
        kind  = $urandom_range(0, 99);
        width = $urandom_range(1, 3);
        pos   = $urandom_range(0, SENSOR_COUNT - width);
        if (kind < 40) return SENSOR_COUNT'(((1 << width) - 1) << pos);
        if (kind < 65) return SENSOR_COUNT'($urandom);
        if (kind < 90) return '0;
        return '1;
    endfunction

    // One full frame in sensor order, now and then with a reading from a
    // sensor that does not exist in between.
    task automatic run_frame(logic [SENSOR_COUNT-1:0] pattern);
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_reading(3'($urandom_range(SENSOR_COUNT, 7)), 16'($urandom),
                             16'($urandom));
            send_reading(3'(i), pick_count(pattern[i], clear_thr_cfg),
                         pick_count(pattern[i], blue_thr_cfg));
        end
    endtask

    // Broken sequences: partial frames, or readings in any order.
    task automatic run_noise();
        if ($urandom_range(0, 1) == 0) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                if ($urandom_range(0, 99) < 60)
                    send_reading(3'(i), 16'($urandom), 16'($urandom));
            end
        end else begin
            repeat ($urandom_range(1, 8))
                send_reading(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
        end
    endtask

    // Saturated and zero counts, both lost-line rules, skipped sensors and
    // an index past the last sensor, with the reset register values.
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Dark bar seeds every average: line lost with no previous error.
        for (int i = 0; i < SENSOR_COUNT; i++) send_reading(3'(i), 16'h0000, 16'h0000);
        // Last sensor alone: still lost, now scaled from the previous error.
        send_reading(3'(SENSOR_COUNT - 1), 16'h0000, 16'h0000);
        // Out-of-range index is dropped.
        send_reading(3'd7, 16'hFFFF, 16'hFFFF);
        // Sensor 0 turns white, sensor 1 has clear but no blue.
        send_reading(3'd0, 16'hFFFF, 16'hFFFF);
        send_reading(3'd1, 16'hFFFF, 16'h0000);
        send_reading(3'(SENSOR_COUNT - 1), 16'h0000, 16'h0000);
        // Sensor 0 keeps its white bit while skipped.
        send_reading(3'(SENSOR_COUNT - 1), 16'hFFFF, 16'hFFFF);
        // Fully white bar.
        for (int i = 0; i < SENSOR_COUNT; i++) send_reading(3'(i), 16'hFFFF, 16'hFFFF);
        wait_quiet();
    endtask

    // Register extremes, each followed by a few frames.
    task automatic test_register_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_settings(16'd0, 16'd0, 16'd0, 15'd0, 15'd0, 7'd0);
        repeat (3) run_frame(choose_pattern());
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 7'd100);
        repeat (3) run_frame(choose_pattern());
        apply_settings(16'hFFFF, 16'd0, 16'd0, 15'h7FFF, 15'h7FFF, 7'd100);
        repeat (2) run_frame(choose_pattern());
        repeat (2) run_frame('0);
        apply_settings(EMA_ALPHA_RST, CLEAR_THR_RST, BLUE_THR_RST, PROP_GAIN_RST,
                       INTEGRAL_GAIN_RST, INTEGRAL_LIMIT_RST);
        repeat (3) run_frame(choose_pattern());
        wait_quiet();
    endtask

    // Random traffic: mostly runs of frames that hold one line pattern,
    // with some broken sequences in between.
    task automatic test_traffic(int idle_pct, int stall_pct);
        logic [15:0]             alpha;
        logic [15:0]             clear_thr;
        logic [SENSOR_COUNT-1:0] pattern;
        int                      start;
        int                      pick;
        pick  = $urandom_range(0, 3);
        alpha = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'($urandom) :
                16'($urandom_range(8000, 40000));
        pick  = $urandom_range(0, 9);
        clear_thr = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd0 :
                    16'($urandom_range(0, 20000));
        apply_settings(alpha, clear_thr, 16'($urandom_range(0, 8000)),
                       15'($urandom_range(0, 32767)),
                       ($urandom_range(0, 1) == 0) ? 15'($urandom_range(0, 500)) :
                                                     15'($urandom_range(0, 32767)),
                       7'($urandom_range(0, 100)));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = readings_sent;
        while (readings_sent - start < PHASE_READS) begin
            if ($urandom_range(0, 99) < 80) begin
                pattern = choose_pattern();
                repeat ($urandom_range(1, 6)) run_frame(pattern);
            end else begin
                run_noise();
            end
        end
        wait_quiet();
    endtask

    initial begin
        // Predictor state after reset.
        alpha_cfg     = EMA_ALPHA_RST;
        clear_thr_cfg = CLEAR_THR_RST;
        blue_thr_cfg  = BLUE_THR_RST;
        kp_cfg        = PROP_GAIN_RST;
        ki_cfg        = INTEGRAL_GAIN_RST;
        ilimit_cfg    = INTEGRAL_LIMIT_RST;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            clear_avg[i] = '0;
            blue_avg[i]  = '0;
            seeded[i]    = 1'b0;
        end
        for (int i = 0; i < AVERAGE_TAPS; i++) err_hist[i] = 0;
        white_bits    = '0;
        hist_slot     = 0;
        last_smoothed = 0;
        integral_acc  = 0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_register_extremes();
        test_traffic(0, 0);
        test_traffic(57, 0);
        test_traffic(0, 57);
        test_traffic(37, 37);

        wait_quiet();
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/lfps_pkg.sv
hdl/lfps_mac.sv
hdl/line_follow_pi_steering.sv
hdl/lfps_checker.sv
tb/sv/tb_line_follow_pi_steering.sv
